FILE: src/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types and constants of the oriented-box overlap core: store entry
// layout, job and axis-kind codes, and small index helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package obb_pkg;

   typedef logic [3:0] ent_type;
   typedef logic [1:0] comp_idx_type;
   typedef logic [1:0] job_type;
   typedef logic [1:0] kind_type;

   localparam int NUM_ENT = 10;

   // store layout: box * 5 + slot
   localparam ent_type ENT_A_CENTER = 4'd0;
   localparam ent_type ENT_A_AXIS0  = 4'd1;
   localparam ent_type ENT_A_HALF   = 4'd4;
   localparam ent_type ENT_B_CENTER = 4'd5;
   localparam ent_type ENT_B_AXIS0  = 4'd6;
   localparam ent_type ENT_B_HALF   = 4'd9;

   localparam logic [2:0] SLOT_HALF = 3'd4;

   // multiply-accumulate jobs
   localparam job_type JOB_CROSS = 2'd0;  // cross product component
   localparam job_type JOB_DIST  = 2'd1;  // center offset onto the axis
   localparam job_type JOB_DOT   = 2'd2;  // axis onto a box axis
   localparam job_type JOB_RAD   = 2'd3;  // scaled by a half-length

   localparam kind_type KIND_FACE_A = 2'd0;
   localparam kind_type KIND_FACE_B = 2'd1;
   localparam kind_type KIND_CROSS  = 2'd2;

   function automatic comp_idx_type next3(input comp_idx_type p);
      comp_idx_type r;
      unique case (p)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic comp_idx_type prev3(input comp_idx_type p);
      comp_idx_type r;
      unique case (p)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/obb_overlap_separating_axis_core.sv
// An item flagged last starts the test; the result comes sooner when an axis
//   separates than when none does.
// Throughput: one item at a time; all products go through one shared
//   (COORD_WIDTH+1)-bit multiply-accumulate unit, one digit per cycle.
// Reset clears the sequencer and the result register; the vector store is not
//   cleared and must be fully written before the first test.
// ----------------------------------------------------------------------------
// obb_overlap_separating_axis_core
// Separating-axis overlap test of two oriented boxes on 15 axes, exact fixed
// point, computed by a digit-serial multiply-accumulate under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_overlap_separating_axis_core #(
   parameter int COORD_WIDTH    = 24,
   parameter int AXIS_FRAC_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_box_select,
   input  wire logic [2:0]                    req_slot,
   input  wire logic signed [COORD_WIDTH-1:0] req_comp_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_comp_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_comp_z,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_hit
);
   import obb_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int F  = AXIS_FRAC_BITS;
   localparam int YW = W + 1;        // multiplier narrow operand
   localparam int LW = 2 * W + 1;    // axis vector under test
   localparam int PW = 3 * W + 3;    // magnitude of a dot product
   localparam int XW = 3 * W + 4;    // wide operand, signed
   localparam int EW = 4 * W;        // wide operand split into four digits
   localparam int MW = 2 * W + 2;    // one partial product
   localparam int AW = 4 * W + 8;    // accumulators

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_IV0   = 4'd1;
   localparam logic [3:0] ST_IV1   = 4'd2;
   localparam logic [3:0] ST_LSET  = 4'd3;
   localparam logic [3:0] ST_MAC   = 4'd4;
   localparam logic [3:0] ST_DRAIN = 4'd5;
   localparam logic [3:0] ST_POST  = 4'd6;
   localparam logic [3:0] ST_TERM  = 4'd7;
   localparam logic [3:0] ST_CMP   = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   // vector store, no reset
   logic signed [W-1:0] store_ff [NUM_ENT][3];

   logic [3:0]   state_ff, state_in;
   job_type      job_ff, job_in;
   comp_idx_type term_ff, term_in;
   logic [1:0]   dg_ff, dg_in;
   comp_idx_type comp_ff, comp_in;
   kind_type     kind_ff, kind_in;
   comp_idx_type ai_ff, ai_in;
   comp_idx_type bj_ff, bj_in;
   logic         kbox_ff, kbox_in;
   comp_idx_type km_ff, km_in;
   logic         mac_vld_ff, mac_vld_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_hit_ff, rsp_hit_in;
   logic         res_ff, res_in;

   logic signed [YW-1:0] iv_ff [3];
   logic signed [YW-1:0] iv_in [3];
   logic signed [W-1:0]  t_ff [3];
   logic signed [W-1:0]  t_in [3];
   logic signed [LW-1:0] l_ff [3];
   logic signed [LW-1:0] l_in [3];
   logic [PW-1:0]        p_ff, p_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] rsum_ff, rsum_in;
   logic [AW-1:0]        d_ff, d_in;
   logic signed [MW-1:0] prod_ff, prod_in;
   logic [1:0]           dgq_ff, dgq_in;
   logic                 tgt_rsum_ff, tgt_rsum_in;

   ent_type              rd_idx;
   comp_idx_type         rd_comp;
   logic signed [W-1:0]  rd_raw;
   logic signed [YW-1:0] rd_sx;
   logic signed [YW-1:0] rd_abs;
   comp_idx_type         q_idx, r_idx;
   logic [1:0]           dg_last;
   comp_idx_type         term_last;
   logic signed [XW-1:0] x_sel;
   logic signed [EW-1:0] x_ext;
   logic [W-1:0]         digit;
   logic signed [W:0]    dig_s;
   logic signed [YW-1:0] y_sel;
   logic signed [MW-1:0] prod_c;
   logic signed [AW-1:0] shifted;
   logic signed [AW-1:0] own_val;
   logic signed [AW-1:0] add_base, add_op, add_sum;
   logic signed [AW-1:0] acc_mag;
   logic                 term_own, term_skip, last_k;
   logic                 req_take;
   ent_type              wr_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign wr_idx    = req_box_select ? ENT_B_CENTER + ent_type'(req_slot)
                                     : ent_type'(req_slot);

   assign q_idx = next3(comp_ff);
   assign r_idx = prev3(comp_ff);

   // store read port
   always_comb begin
      rd_idx  = ENT_A_CENTER;
      rd_comp = 2'd0;
      unique case (state_ff)
         ST_IV1:  rd_idx = ENT_B_CENTER;
         ST_LSET: rd_idx = (kind_ff == KIND_FACE_B) ? ENT_B_AXIS0 + ent_type'(bj_ff)
                                                    : ENT_A_AXIS0 + ent_type'(ai_ff);
         ST_MAC: begin
            case (job_ff)
               JOB_CROSS: begin
                  rd_idx  = ENT_B_AXIS0 + ent_type'(bj_ff);
                  rd_comp = term_ff[0] ? q_idx : r_idx;
               end
               JOB_DOT: begin
                  rd_idx  = kbox_ff ? ENT_B_AXIS0 + ent_type'(km_ff)
                                    : ENT_A_AXIS0 + ent_type'(km_ff);
                  rd_comp = term_ff;
               end
               JOB_RAD: begin
                  rd_idx  = kbox_ff ? ENT_B_HALF : ENT_A_HALF;
                  rd_comp = km_ff;
               end
               default: ;
            endcase
         end
         ST_TERM: begin
            rd_idx  = kbox_ff ? ENT_B_HALF : ENT_A_HALF;
            rd_comp = km_ff;
         end
         default: ;
      endcase
   end

   assign rd_raw = store_ff[rd_idx][rd_comp];
   assign rd_sx  = YW'(rd_raw);
   assign rd_abs = rd_raw[W-1] ? -rd_sx : rd_sx;

   // operand select for the shared multiplier
   always_comb begin
      dg_last   = 2'd2;
      term_last = 2'd2;
      x_sel     = XW'(l_ff[term_ff]);
      y_sel     = rd_sx;
      case (job_ff)
         JOB_CROSS: begin
            dg_last   = 2'd0;
            term_last = 2'd1;
            x_sel     = term_ff[0] ? XW'(t_ff[r_idx]) : XW'(t_ff[q_idx]);
            y_sel     = term_ff[0] ? -rd_sx : rd_sx;
         end
         JOB_DIST: y_sel = iv_ff[term_ff];
         JOB_DOT:  y_sel = rd_sx;
         default: begin
            dg_last   = 2'd3;
            term_last = 2'd0;
            x_sel     = signed'({1'b0, p_ff});
            y_sel     = rd_abs;
         end
      endcase
   end

   assign x_ext  = EW'(x_sel);
   assign digit  = x_ext[dg_ff*W +: W];
   // only the top digit carries the sign
   assign dig_s  = (dg_ff == dg_last) ? signed'({digit[W-1], digit})
                                      : signed'({1'b0, digit});
   assign prod_c = dig_s * y_sel;

   assign shifted  = AW'(prod_ff) << (W * dgq_ff);
   assign own_val  = AW'(rd_abs) << (2 * F);
   assign add_op   = (state_ff == ST_TERM) ? own_val : shifted;
   assign add_base = ((state_ff == ST_TERM) || tgt_rsum_ff) ? rsum_ff : acc_ff;
   assign add_sum  = add_base + add_op;
   assign acc_mag  = acc_ff[AW-1] ? -acc_ff : acc_ff;

   assign term_own  = ((kind_ff == KIND_FACE_A) && !kbox_ff && (km_ff == ai_ff)) ||
                      ((kind_ff == KIND_FACE_B) &&  kbox_ff && (km_ff == bj_ff));
   assign term_skip = ((kind_ff == KIND_FACE_A) && !kbox_ff && (km_ff != ai_ff)) ||
                      ((kind_ff == KIND_FACE_B) &&  kbox_ff && (km_ff != bj_ff)) ||
                      ((kind_ff == KIND_CROSS) &&
                       ((!kbox_ff && (km_ff == ai_ff)) || (kbox_ff && (km_ff == bj_ff))));
   assign last_k    = kbox_ff && (km_ff == 2'd2);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      term_in      = term_ff;
      dg_in        = dg_ff;
      comp_in      = comp_ff;
      kind_in      = kind_ff;
      ai_in        = ai_ff;
      bj_in        = bj_ff;
      kbox_in      = kbox_ff;
      km_in        = km_ff;
      mac_vld_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      res_in       = res_ff;
      iv_in        = iv_ff;
      t_in         = t_ff;
      l_in         = l_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      rsum_in      = rsum_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      dgq_in       = dgq_ff;
      tgt_rsum_in  = tgt_rsum_ff;

      if (mac_vld_ff) begin
         if (tgt_rsum_ff) rsum_in = add_sum;
         else acc_in = add_sum;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_last) state_in = ST_IV0;
         end
         ST_IV0: begin
            for (int i = 0; i < 3; i++) iv_in[i] = YW'(store_ff[rd_idx][i]);
            acc_in   = '0;
            rsum_in  = '0;
            kind_in  = KIND_FACE_A;
            ai_in    = 2'd0;
            bj_in    = 2'd0;
            state_in = ST_IV1;
         end
         ST_IV1: begin
            for (int i = 0; i < 3; i++) iv_in[i] = iv_ff[i] - YW'(store_ff[rd_idx][i]);
            state_in = ST_LSET;
         end
         ST_LSET: begin
            term_in = 2'd0;
            dg_in   = 2'd0;
            comp_in = 2'd0;
            if (kind_ff == KIND_CROSS) begin
               for (int i = 0; i < 3; i++) t_in[i] = store_ff[rd_idx][i];
               job_in = JOB_CROSS;
            end else begin
               for (int i = 0; i < 3; i++) l_in[i] = LW'(store_ff[rd_idx][i]);
               job_in = JOB_DIST;
            end
            state_in = ST_MAC;
         end
         ST_MAC: begin
            mac_vld_in  = 1'b1;
            prod_in     = prod_c;
            dgq_in      = dg_ff;
            tgt_rsum_in = (job_ff == JOB_RAD);
            if (dg_ff == dg_last) begin
               dg_in = 2'd0;
               if (term_ff == term_last) state_in = ST_DRAIN;
               else term_in = term_ff + 2'd1;
            end else begin
               dg_in = dg_ff + 2'd1;
            end
         end
         ST_DRAIN: state_in = ST_POST;
         ST_POST: begin
            acc_in  = '0;
            term_in = 2'd0;
            dg_in   = 2'd0;
            case (job_ff)
               JOB_CROSS: begin
                  l_in[comp_ff] = LW'(acc_ff);
                  if (comp_ff == 2'd2) job_in = JOB_DIST;
                  else comp_in = comp_ff + 2'd1;
                  state_in = ST_MAC;
               end
               JOB_DIST: begin
                  d_in     = acc_mag << F;
                  rsum_in  = '0;
                  kbox_in  = 1'b0;
                  km_in    = 2'd0;
                  state_in = ST_TERM;
               end
               JOB_DOT: begin
                  p_in     = PW'(acc_mag);
                  job_in   = JOB_RAD;
                  state_in = ST_MAC;
               end
               default: begin
                  if (last_k) begin
                     state_in = ST_CMP;
                  end else begin
                     state_in = ST_TERM;
                     if (km_ff == 2'd2) begin
                        km_in   = 2'd0;
                        kbox_in = 1'b1;
                     end else begin
                        km_in = km_ff + 2'd1;
                     end
                  end
               end
            endcase
         end
         ST_TERM: begin
            if (term_own || term_skip) begin
               if (term_own) rsum_in = add_sum;
               if (last_k) begin
                  state_in = ST_CMP;
               end else if (km_ff == 2'd2) begin
                  km_in   = 2'd0;
                  kbox_in = 1'b1;
               end else begin
                  km_in = km_ff + 2'd1;
               end
            end else begin
               job_in   = JOB_DOT;
               term_in  = 2'd0;
               dg_in    = 2'd0;
               state_in = ST_MAC;
            end
         end
         ST_CMP: begin
            state_in = ST_LSET;
            if (d_ff > AW'(rsum_ff)) begin
               res_in   = 1'b0;
               state_in = ST_FIN;
            end else begin
               case (kind_ff)
                  KIND_FACE_A: begin
                     if (ai_ff == 2'd2) begin
                        kind_in = KIND_FACE_B;
                        bj_in   = 2'd0;
                     end else begin
                        ai_in = ai_ff + 2'd1;
                     end
                  end
                  KIND_FACE_B: begin
                     if (bj_ff == 2'd2) begin
                        kind_in = KIND_CROSS;
                        ai_in   = 2'd0;
                        bj_in   = 2'd0;
                     end else begin
                        bj_in = bj_ff + 2'd1;
                     end
                  end
                  default: begin
                     if (bj_ff == 2'd2) begin
                        if (ai_ff == 2'd2) begin
                           res_in   = 1'b1;
                           state_in = ST_FIN;
                        end else begin
                           ai_in = ai_ff + 2'd1;
                           bj_in = 2'd0;
                        end
                     end else begin
                        bj_in = bj_ff + 2'd1;
                     end
                  end
               endcase
            end
         end
         ST_FIN: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take && (req_slot <= SLOT_HALF)) begin
         store_ff[wr_idx][0] <= req_comp_x;
         store_ff[wr_idx][1] <= req_comp_y;
         store_ff[wr_idx][2] <= req_comp_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_CROSS;
         term_ff      <= 2'd0;
         dg_ff        <= 2'd0;
         comp_ff      <= 2'd0;
         kind_ff      <= KIND_FACE_A;
         ai_ff        <= 2'd0;
         bj_ff        <= 2'd0;
         kbox_ff      <= 1'b0;
         km_ff        <= 2'd0;
         mac_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         term_ff      <= term_in;
         dg_ff        <= dg_in;
         comp_ff      <= comp_in;
         kind_ff      <= kind_in;
         ai_ff        <= ai_in;
         bj_ff        <= bj_in;
         kbox_ff      <= kbox_in;
         km_ff        <= km_in;
         mac_vld_ff   <= mac_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      res_ff      <= res_in;
      iv_ff       <= iv_in;
      t_ff        <= t_in;
      l_ff        <= l_in;
      p_ff        <= p_in;
      acc_ff      <= acc_in;
      rsum_ff     <= rsum_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      dgq_ff      <= dgq_in;
      tgt_rsum_ff <= tgt_rsum_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("result raised outside the finish step");
   a_mac_from_issue: assert property (@(posedge clock) disable iff (reset)
      mac_vld_ff |-> $past(state_ff) == ST_MAC)
      else $error("product in flight without an issue");
   a_term_idle_mac: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM || state_ff == ST_POST || state_ff == ST_CMP) |-> !mac_vld_ff)
      else $error("product in flight while accumulators are read");
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_last) |=> state_ff == ST_IV0)
      else $error("last item did not start the test");
`endif

endmodule

`default_nettype wire
